// ===== src/tteq_pkg.sv =====
// tteq_pkg: types, sizes and codes shared by the timed event queue unit.
// No dependencies; imported by tteq_store, per_thread_timed_event_queue_unit, tteq_event_checker and the testbench.
package tteq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_THREADS = 4;

  localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int TI_W   = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  // item kinds
  localparam logic [1:0] KIND_SCHED = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_CLR   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_SCHEDULED = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_POPPED    = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_LIMIT     = 3'd4;

  // store operations
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  thread_index;
    logic [15:0] duration;
    logic [7:0]  work_tag;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] event_time;
    logic [1:0]  event_thread;
    logic        event_is_end;
    logic [7:0]  event_tag;
  } result_t;

  // one stored event, 43 bits
  typedef struct packed {
    logic [31:0] time_val;
    logic [1:0]  thread;
    logic        is_end;
    logic [7:0]  tag;
  } ev_t;

  typedef struct packed {
    logic valid;
    logic op;
    ev_t  ev;
  } store_cmd_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] count;
    ev_t              ev;
  } store_sts_t;

endpackage

// ===== src/tteq_ram.sv =====
// tteq_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module tteq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/tteq_store.sv =====
// tteq_store: time-sorted event store in a circular RAM; insertion walks from
// the tail one entry a cycle through one shared time comparator. Uses tteq_pkg, tteq_ram.
module tteq_store
  import tteq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  store_cmd_t cmd,
  output store_sts_t sts
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_PUT   = 2'd2;
  localparam logic [1:0] S_POPRD = 2'd3;

  logic [1:0]        state;
  logic [ADDR_W-1:0] head;
  logic [ADDR_W-1:0] tail;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] ppos;   // slot the new event may take
  logic [ADDR_W-1:0] rptr;   // slot being compared (one before ppos)
  logic [CNT_W-1:0]  pos;    // entries still ahead of ppos
  ev_t               ev_new;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  ev_t               wr_data;
  logic [ADDR_W-1:0] rd_addr;
  ev_t               rd_data;
  logic              shift;
  logic              finish;

  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
    ptr_inc = (p == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] ptr_dec(input logic [ADDR_W-1:0] p);
    ptr_dec = (p == '0) ? ADDR_W'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

  tteq_ram #(
    .WIDTH ($bits(ev_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // strict compare keeps equal times in arrival order
  assign shift = (state == S_CMP) && (ev_new.time_val < rd_data.time_val);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ppos;
    wr_data = ev_new;
    rd_addr = ptr_dec(rptr);
    finish  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd.valid && cmd.op == OP_POP) begin
          rd_addr = head;
        end else begin
          rd_addr = ptr_dec(tail);
        end
      end
      S_CMP: begin
        wr_en = 1'b1;
        if (shift) begin
          wr_data = rd_data;
        end else begin
          finish = 1'b1;
        end
      end
      S_PUT: begin
        wr_en  = 1'b1;
        finish = 1'b1;
      end
      S_POPRD: begin
        rd_addr = head;
      end
      default: begin
        rd_addr = head;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            if (cmd.op == OP_POP) begin
              state <= S_POPRD;
            end else if (count == '0) begin
              state <= S_PUT;
            end else begin
              state <= S_CMP;
            end
          end
        end
        S_CMP: begin
          if (!shift) begin
            state <= S_IDLE;
          end else if (pos == CNT_W'(1)) begin
            state <= S_PUT;
          end
        end
        S_PUT: state <= S_IDLE;
        S_POPRD: begin
          state <= S_IDLE;
          head  <= ptr_inc(head);
          count <= count - 1'b1;
        end
        default: state <= S_IDLE;
      endcase
      if (finish) begin
        tail  <= ptr_inc(tail);
        count <= count + 1'b1;
      end
    end
  end

  // walk pointers, no reset needed
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd.valid) begin
      ev_new <= cmd.ev;
      ppos   <= tail;
      rptr   <= ptr_dec(tail);
      pos    <= count;
    end else if (shift) begin
      ppos <= rptr;
      rptr <= ptr_dec(rptr);
      pos  <= pos - 1'b1;
    end
  end

  assign sts.done  = finish || (state == S_POPRD);
  assign sts.count = count;
  assign sts.ev    = rd_data;

  a_cmd_when_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.valid |-> state == S_IDLE)
    else $error("store command while busy");

  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    ADDR_W'(tail - head) == ADDR_W'(count))
    else $error("head/tail disagree with count");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    state == S_POPRD |=> count == CNT_W'($past(count) - 1'b1))
    else $error("pop did not drop count");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("store overflow");

endmodule

// ===== src/per_thread_timed_event_queue_unit.sv =====
// Per-thread timed event queue: one transaction in, one result transaction out.
// Schedule: the begin and the end event go in by two sorted insertions, each walking
// tail-first through the event RAM and shifting one stored event per step.
// Pop, queue-full, empty, limit and clock reset need no walk. One item in flight; its
// result is valid from the cycle the next item can be taken, later if output stalls.
// Reset (rst, synchronous): queue empty, times zero, time limit all ones.
module per_thread_timed_event_queue_unit
  import tteq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_wen,
  input  logic [31:0] cfg_data
);

  // sequencer codes
  localparam logic [2:0] T_IDLE = 3'd0;
  localparam logic [2:0] T_DEC  = 3'd1;  // decode, checks, begin time
  localparam logic [2:0] T_CALC = 3'd2;  // end time, issue begin event
  localparam logic [2:0] T_INS0 = 3'd3;  // wait for begin insertion
  localparam logic [2:0] T_ISS1 = 3'd4;  // issue end event
  localparam logic [2:0] T_INS1 = 3'd5;  // wait for end insertion
  localparam logic [2:0] T_POP  = 3'd6;  // wait for popped event
  localparam logic [2:0] T_RES  = 3'd7;  // result held until output slot frees

  logic [2:0]        state;
  item_t             item_r;
  logic [31:0]       time_limit;
  logic [31:0]       cur_time;
  logic [31:0]       idle_time [NUM_THREADS];
  logic [31:0]       begin_r;
  logic [31:0]       end_r;
  result_t           res_r;

  logic              accept;
  logic [1:0]        th_wrap;
  logic [TI_W-1:0]   th_idx;
  logic [32:0]       end_sum;
  logic              q_full;
  logic              out_free;
  result_t           dec_res;
  store_cmd_t        cmd;
  store_sts_t        sts;

  tteq_store u_store (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts)
  );

  // thread index wrapped into range by repeated subtraction (at most three steps)
  always_comb begin
    th_wrap = item_r.thread_index;
    for (int k = 0; k < 3; k++) begin
      if ({2'b00, th_wrap} >= 4'(NUM_THREADS)) begin
        th_wrap = th_wrap - 2'(NUM_THREADS);
      end
    end
  end
  assign th_idx = TI_W'(th_wrap);

  assign accept   = item_valid && !item_stall;
  assign item_stall = (state != T_IDLE);
  assign out_free = !result_valid || !result_stall;
  assign q_full   = sts.count > CNT_W'(QUEUE_DEPTH - 2);

  // saturating end time
  assign end_sum = {1'b0, begin_r} + {17'b0, item_r.duration};

  // result decided at decode; a granted pop fills it in later
  always_comb begin
    dec_res = '0;
    unique case (item_r.kind)
      KIND_SCHED: dec_res.status = q_full ? ST_FULL : ST_SCHEDULED;
      KIND_POP: begin
        if (sts.count == '0) begin
          dec_res.status = ST_EMPTY;
        end else if (cur_time > time_limit) begin
          dec_res.status = ST_LIMIT;
        end
      end
      default: ;
    endcase
  end

  // store commands
  always_comb begin
    cmd          = '0;
    cmd.ev.tag   = item_r.work_tag;
    cmd.ev.thread = th_wrap;
    unique case (state)
      T_DEC: begin
        if (item_r.kind == KIND_POP && sts.count != '0 && cur_time <= time_limit) begin
          cmd.valid = 1'b1;
          cmd.op    = OP_POP;
        end
      end
      T_CALC: begin
        cmd.valid       = 1'b1;
        cmd.op          = OP_INSERT;
        cmd.ev.time_val = begin_r;
      end
      T_ISS1: begin
        cmd.valid       = 1'b1;
        cmd.op          = OP_INSERT;
        cmd.ev.time_val = end_r;
        cmd.ev.is_end   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= T_IDLE;
      time_limit <= TIME_MAX;
      cur_time   <= '0;
      for (int i = 0; i < NUM_THREADS; i++) begin
        idle_time[i] <= '0;
      end
    end else begin
      if (cfg_wen) begin
        time_limit <= cfg_data;
      end
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            state <= T_DEC;
          end
        end
        T_DEC: begin
          unique case (item_r.kind)
            KIND_SCHED: state <= q_full ? T_RES : T_CALC;
            KIND_POP: begin
              if (sts.count == '0 || cur_time > time_limit) begin
                state <= T_RES;
              end else begin
                state <= T_POP;
              end
            end
            KIND_CLR: begin
              cur_time <= '0;
              state    <= T_RES;
            end
            default: state <= T_RES;
          endcase
        end
        T_CALC: state <= T_INS0;
        T_INS0: begin
          if (sts.done) begin
            state <= T_ISS1;
          end
        end
        T_ISS1: begin
          idle_time[th_idx] <= end_r;
          state             <= T_INS1;
        end
        T_INS1: begin
          if (sts.done) begin
            state <= T_RES;
          end
        end
        T_POP: begin
          if (sts.done) begin
            cur_time <= sts.ev.time_val;
            state    <= T_RES;
          end
        end
        T_RES: begin
          if (out_free) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // payload: item, times, pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item;
    end
    if (state == T_DEC) begin
      begin_r <= (idle_time[th_idx] > cur_time) ? idle_time[th_idx] : cur_time;
      res_r   <= dec_res;
    end
    if (state == T_CALC) begin
      end_r <= end_sum[32] ? TIME_MAX : end_sum[31:0];
    end
    if (state == T_POP && sts.done) begin
      res_r <= '{status:       ST_POPPED,
                 event_time:   sts.ev.time_val,
                 event_thread: sts.ev.thread,
                 event_is_end: sts.ev.is_end,
                 event_tag:    sts.ev.tag};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == T_RES && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == T_RES && out_free) begin
      result <= res_r;
    end
  end

endmodule

// ===== sim/tteq_event_checker.sv =====
// tteq_event_checker: watches both channels of the timed event queue unit, keeps its own
// copy of the queue state, predicts one reply per transaction and compares in order.
// Depends on tteq_pkg for the payload structs, sizes and codes.
module tteq_event_checker
  import tteq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  item_t       item,
  input  logic        result_valid,
  input  logic        result_stall,
  input  result_t     result,
  input  logic        cfg_wen,
  input  logic [31:0] cfg_data,
  output int          error_total,
  output int          replies_owed
);

  // replies still owed; the block holds at most two in flight
  localparam int REPLY_SLOTS = 8;

  logic [31:0] limit_copy;
  logic [31:0] now_ticks;
  logic [31:0] thread_free_at [NUM_THREADS];
  ev_t         ev_list [QUEUE_DEPTH];
  int          ev_fill;
  result_t     reply_buf [REPLY_SLOTS];
  int          buf_rd;
  int          buf_wr;
  int          buf_fill;
  int          reported;

  initial begin
    error_total  = 0;
    replies_owed = 0;
    reported     = 0;
  end

  // sorted insert: behind every event with an equal or earlier time
  function automatic void place_event(ev_t e);
    int pos;
    pos = ev_fill;
    while (pos > 0 && e.time_val < ev_list[pos-1].time_val) begin
      ev_list[pos] = ev_list[pos-1];
      pos--;
    end
    ev_list[pos] = e;
    ev_fill++;
  endfunction

  function automatic result_t advance_event_queue(item_t it);
    result_t     r;
    int          th;
    logic [31:0] start_t;
    logic [31:0] stop_t;
    logic [32:0] sum;
    ev_t         e;
    r  = '0;
    th = int'(it.thread_index) % NUM_THREADS;
    case (it.kind)
      KIND_SCHED: begin
        if (QUEUE_DEPTH - ev_fill < 2) begin
          r.status = ST_FULL;
        end else begin
          start_t = (thread_free_at[th] > now_ticks) ? thread_free_at[th] : now_ticks;
          sum     = {1'b0, start_t} + {17'd0, it.duration};
          stop_t  = sum[32] ? TIME_MAX : sum[31:0];
          e.time_val = start_t;
          e.thread   = 2'(th);
          e.is_end   = 1'b0;
          e.tag      = it.work_tag;
          place_event(e);
          e.time_val = stop_t;
          e.is_end   = 1'b1;
          place_event(e);
          thread_free_at[th] = stop_t;
          r.status = ST_SCHEDULED;
        end
      end
      KIND_POP: begin
        if (ev_fill == 0) begin
          r.status = ST_EMPTY;
        end else if (now_ticks > limit_copy) begin
          r.status = ST_LIMIT;
        end else begin
          e = ev_list[0];
          for (int i = 1; i < ev_fill; i++) ev_list[i-1] = ev_list[i];
          ev_fill--;
          now_ticks      = e.time_val;
          r.status       = ST_POPPED;
          r.event_time   = e.time_val;
          r.event_thread = e.thread;
          r.event_is_end = e.is_end;
          r.event_tag    = e.tag;
        end
      end
      KIND_CLR: begin
        now_ticks = '0;
        r.status  = ST_SCHEDULED;
      end
      default: r.status = ST_SCHEDULED;
    endcase
    return r;
  endfunction

  task automatic report_bad(input string what, input result_t want, input result_t got);
    error_total++;
    if (reported < 10) begin
      $display("%s: want st %0d t %0d th %0d end %0d tag %0h,", what, want.status,
               want.event_time, want.event_thread, want.event_is_end, want.event_tag);
      $display("  got st %0d t %0d th %0d end %0d tag %0h", got.status, got.event_time,
               got.event_thread, got.event_is_end, got.event_tag);
    end
    reported++;
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      limit_copy = TIME_MAX;
      now_ticks  = '0;
      foreach (thread_free_at[i]) thread_free_at[i] = '0;
      ev_fill  = 0;
      buf_rd   = 0;
      buf_wr   = 0;
      buf_fill = 0;
    end else begin
      if (cfg_wen) limit_copy = cfg_data;
      // reply first: it can only belong to an earlier transaction
      if (result_valid && !result_stall) begin
        if (buf_fill == 0) begin
          report_bad("unexpected reply", '0, result);
        end else begin
          want     = reply_buf[buf_rd];
          buf_rd   = (buf_rd + 1) % REPLY_SLOTS;
          buf_fill--;
          if (result !== want) report_bad("reply mismatch", want, result);
        end
      end
      if (item_valid && !item_stall) begin
        if (buf_fill == REPLY_SLOTS) begin
          report_bad("reply backlog overflow", '0, '0);
        end else begin
          reply_buf[buf_wr] = advance_event_queue(item);
          buf_wr   = (buf_wr + 1) % REPLY_SLOTS;
          buf_fill++;
        end
      end
    end
    replies_owed = buf_fill;
  end

endmodule

// ===== sim/tb_per_thread_timed_event_queue_unit.sv =====
// tb_per_thread_timed_event_queue_unit: stimulus and verdict for the timed event queue unit.
// Depends on tteq_pkg, per_thread_timed_event_queue_unit and tteq_event_checker.
module tb_per_thread_timed_event_queue_unit
  import tteq_pkg::*;
();

  // the spare kind code; the block treats it as a no-op
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam int QUIET_LIMIT   = 4000; // cycles with no transaction before giving up
  localparam int SETTLE_CYCLES = 48;   // longer than the slowest schedule walk
  localparam int PHASE_ITEMS   = 226;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  item_t       item;
  logic        result_valid;
  logic        result_stall;
  result_t     result;
  logic        cfg_wen;
  logic [31:0] cfg_data;

  int error_total;
  int replies_owed;
  int results_seen = 0;
  int burst_left;
  int quiet_cycles;
  bit steady_send;

  per_thread_timed_event_queue_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_wen      (cfg_wen),
    .cfg_data     (cfg_data)
  );

  tteq_event_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_wen      (cfg_wen),
    .cfg_data     (cfg_data),
    .error_total  (error_total),
    .replies_owed (replies_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) results_seen <= results_seen + 1;
  end

  // Watchdog: any transaction on either channel, or reset, clears the count.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("FAIL");
    $finish;
  end

  // Receiver stall pattern: modes are redrawn at random. Twice in the run it
  // holds off for a long stretch, so the block backs up and stalls its input while the
  // sender keeps offering.
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int next_hold;
    result_stall = 1'b0;
    mode      = 0;
    mode_left = 50;
    hold_left = 0;
    next_hold = 150;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && results_seen >= next_hold && next_hold < 1000) begin
        hold_left = $urandom_range(150, 250);
        next_hold += 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 3) == 0);
          2: result_stall <= ($urandom_range(0, 9) < 7);
          default: result_stall <= ~result_stall;
        endcase
      end
    end
  end

  function automatic item_t mk(input logic [1:0] kind, input logic [1:0] th,
                               input logic [15:0] dur, input logic [7:0] tag);
    item_t it;
    it.kind         = kind;
    it.thread_index = th;
    it.duration     = dur;
    it.work_tag     = tag;
    return it;
  endfunction

  // mostly short durations, so equal times and FIFO ties are common
  function automatic logic [15:0] rand_duration();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return 16'($urandom_range(0, 15));
    if (roll == 6) return 16'd0;
    if (roll == 7) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // bias 0 fills the store, 1 drains it, 2 is an even mix
  function automatic item_t rand_item(input int bias);
    int         roll;
    int         sched_share;
    logic [1:0] kind;
    roll        = $urandom_range(0, 99);
    sched_share = (bias == 0) ? 75 : (bias == 1) ? 20 : 47;
    if (roll < sched_share) kind = KIND_SCHED;
    else if (roll < 94)     kind = KIND_POP;
    else if (roll < 98)     kind = KIND_CLR;
    else                    kind = KIND_SPARE;
    return mk(kind, 2'($urandom_range(0, 3)), rand_duration(), 8'($urandom_range(0, 255)));
  endfunction

  // One input transaction. Called at a falling edge, returns at a falling edge. Valid
  // stays high across a burst; between bursts the sender idles for a random gap.
  task automatic offer(input item_t it);
    int gap;
    if (!steady_send && burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
  endtask

  // sender pause: nothing goes in until every reply is back
  task automatic wait_drain();
    item_valid <= 1'b0;
    while (replies_owed != 0) @(negedge clk);
  endtask

  task automatic set_limit(input logic [31:0] value);
    cfg_wen  <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_wen  <= 1'b0;
  endtask

  initial begin
    int sent;
    int seg;
    int bias;
    rst         = 1'b1;
    item_valid  = 1'b0;
    item        = '0;
    cfg_wen     = 1'b0;
    cfg_data    = '0;
    burst_left  = 0;
    steady_send = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty pop, spare kind, clock reset on an empty store
    set_limit(TIME_MAX);
    offer(mk(KIND_POP,   2'd0, 16'd0, 8'h00));
    offer(mk(KIND_SPARE, 2'd3, 16'hFFFF, 8'hFF));
    offer(mk(KIND_CLR,   2'd1, 16'd0, 8'h00));
    // eight bookings fill all sixteen slots; zero durations give ties at one time
    offer(mk(KIND_SCHED, 2'd0, 16'd0,    8'h00));
    offer(mk(KIND_SCHED, 2'd1, 16'hFFFF, 8'hFF));
    offer(mk(KIND_SCHED, 2'd0, 16'd5,    8'hA5));
    offer(mk(KIND_SCHED, 2'd3, 16'd0,    8'h5A));
    offer(mk(KIND_SCHED, 2'd2, 16'd1,    8'h01));
    offer(mk(KIND_SCHED, 2'd2, 16'd300,  8'h3C));
    offer(mk(KIND_SCHED, 2'd3, 16'd7,    8'hC3));
    offer(mk(KIND_SCHED, 2'd1, 16'd2,    8'h96));
    // store full: rejected, then a spare kind, a clock reset and two pops
    offer(mk(KIND_SCHED, 2'd0, 16'd9,    8'h11));
    offer(mk(KIND_SPARE, 2'd0, 16'd0,    8'h00));
    offer(mk(KIND_CLR,   2'd0, 16'd0,    8'h00));
    offer(mk(KIND_POP,   2'd0, 16'd0,    8'h00));
    offer(mk(KIND_POP,   2'd0, 16'd0,    8'h00));
    // time limit of zero: a pop is refused once the clock is past it, until the clock is reset
    wait_drain();
    set_limit(32'd0);
    offer(mk(KIND_POP,   2'd0, 16'd0,    8'h00));
    offer(mk(KIND_CLR,   2'd0, 16'd0,    8'h00));
    offer(mk(KIND_POP,   2'd0, 16'd0,    8'h00));
    offer(mk(KIND_POP,   2'd0, 16'd0,    8'h00));

    // random phases, one limit setting each; phase 2 sends without gaps
    for (int p = 0; p < 5; p++) begin
      wait_drain();
      case (p)
        0: set_limit(TIME_MAX);
        1: set_limit(32'd0);
        2: set_limit(32'($urandom_range(0, 400)));
        3: set_limit(32'($urandom));
        default: set_limit(TIME_MAX);
      endcase
      steady_send = (p == 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        bias = $urandom_range(0, 2);
        seg  = $urandom_range(4, 30);
        repeat (seg) begin
          if (sent < PHASE_ITEMS) begin
            offer(rand_item(bias));
            sent++;
          end
        end
      end
    end

    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_total == 0 && replies_owed == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
